@@ rtl/core/mcsps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsps_pkg
// Types, control word layout and microprogram of the step pulse scheduler.
// ----------------------------------------------------------------------------
package mcsps_pkg;

   localparam int PIN_W   = 8;   // width of each pin byte
   localparam int TICK_W  = 8;   // tick counter, due tick, period, step count
   localparam int CHAN_W  = 3;   // channel field width
   localparam int PC_W    = 3;   // microprogram counter
   localparam logic [PIN_W-1:0]  ALL_INACTIVE  = 8'hff;
   localparam logic [TICK_W-1:0] REVERSE_RESET = 8'd75;

   // input operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // datapath actions
   localparam logic [2:0] A_NONE = 3'd0;
   localparam logic [2:0] A_WAIT = 3'd1;
   localparam logic [2:0] A_TICK = 3'd2;
   localparam logic [2:0] A_SCAN = 3'd3;
   localparam logic [2:0] A_SET  = 3'd4;
   localparam logic [2:0] A_EMIT = 3'd5;

   // jump conditions
   localparam logic [1:0] C_ALWAYS = 2'd0;
   localparam logic [1:0] C_ACCEPT = 2'd1;
   localparam logic [1:0] C_LAST   = 2'd2;
   localparam logic [1:0] C_FREE   = 2'd3;

   // microprogram addresses
   localparam logic [PC_W-1:0] PC_WAIT = 3'd0;
   localparam logic [PC_W-1:0] PC_TICK = 3'd1;
   localparam logic [PC_W-1:0] PC_SCAN = 3'd2;
   localparam logic [PC_W-1:0] PC_SET  = 3'd3;
   localparam logic [PC_W-1:0] PC_EMIT = 3'd4;

   typedef struct packed {
      logic [2:0]      action;
      logic [1:0]      cond;
      logic [PC_W-1:0] target;
   } ctl_word_type;

   typedef struct packed {
      logic accepted;
      logic op_set;
      logic last_chan;
      logic out_free;
   } seq_status_type;

   function automatic ctl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      w = '{action: A_NONE, cond: C_ALWAYS, target: PC_WAIT};
      case (pc)
         // accepted tick falls through to PC_TICK, set jumps
         PC_WAIT: w = '{action: A_WAIT, cond: C_ACCEPT, target: PC_SET};
         PC_TICK: w = '{action: A_TICK, cond: C_ALWAYS, target: PC_SCAN};
         PC_SCAN: w = '{action: A_SCAN, cond: C_LAST,   target: PC_EMIT};
         PC_SET:  w = '{action: A_SET,  cond: C_ALWAYS, target: PC_EMIT};
         PC_EMIT: w = '{action: A_EMIT, cond: C_FREE,   target: PC_WAIT};
         default: w = '{action: A_NONE, cond: C_ALWAYS, target: PC_WAIT};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/mcsps_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsps_seq
// Microprogram counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module mcsps_seq (
   input  wire                       clock,
   input  wire                       reset,
   input  mcsps_pkg::seq_status_type status,
   output mcsps_pkg::ctl_word_type   ctl
);
   import mcsps_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;

   assign ctl = ucode_rom(pc_ff);

   always_comb begin
      pc_in = pc_ff;
      unique case (ctl.cond)
         C_ALWAYS: pc_in = ctl.target;
         C_ACCEPT: begin
            if (status.accepted) begin
               pc_in = status.op_set ? ctl.target : pc_ff + PC_W'(1);
            end
         end
         C_LAST: begin
            if (status.last_chan) begin
               pc_in = ctl.target;
            end
         end
         C_FREE: begin
            if (status.out_free) begin
               pc_in = ctl.target;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/multi_channel_step_pulse_scheduler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sequence: a tick transaction passes through TICK, a scan of every channel and EMIT,
//   which waits for a free output, before its result is registered; a set goes through SET and EMIT
// a new request is taken only after EMIT has issued the result of the last one;
//   the scan visits one channel per cycle through a single compare/add datapath
// reset: synchronous; tick counter, periods, due ticks and step counts clear,
//   step pins all high, direction pins low, reverse limit 75
// ----------------------------------------------------------------------------
// multi_channel_step_pulse_scheduler_core
// Multi-channel stepper pulse scheduler driven by a small microprogram.
// ----------------------------------------------------------------------------
module multi_channel_step_pulse_scheduler_core #(
   parameter int CHANNELS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [2:0] channel, [10:3] period, rest zero
   input  wire         req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] step_pins, [15:8] direction_pins
   input  wire         csr_we,
   input  wire  [7:0]  csr_wdata
);
   import mcsps_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(CHANNELS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   ctl_word_type   ctl;
   seq_status_type status;

   logic [TICK_W-1:0] limit_ff;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] period_ff [CHANNELS];
   logic [TICK_W-1:0] period_in [CHANNELS];
   logic [TICK_W-1:0] due_ff    [CHANNELS];
   logic [TICK_W-1:0] due_in    [CHANNELS];
   logic [TICK_W-1:0] count_ff  [CHANNELS];
   logic [TICK_W-1:0] count_in  [CHANNELS];
   logic [PIN_W-1:0]  step_ff, step_in;
   logic [PIN_W-1:0]  dir_ff, dir_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic [TICK_W-1:0] per_ff, per_in;
   logic [IDX_W-1:0]  chan_ff, chan_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic              accepted;
   logic              out_free;
   logic              last_chan;
   logic [PIN_W-1:0]  chan_mask;
   logic [TICK_W-1:0] count_next;

   assign accepted   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign last_chan  = (chan_ff == LAST_IDX);
   assign chan_mask  = PIN_W'(1) << chan_ff;
   assign count_next = count_ff[chan_ff] + TICK_W'(1);

   assign status = '{accepted: accepted, op_set: (req_tuser == OP_SET),
                     last_chan: last_chan, out_free: out_free};

   mcsps_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign req_tready = (ctl.action == A_WAIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      tick_in     = tick_ff;
      period_in   = period_ff;
      due_in      = due_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      dir_in      = dir_ff;
      ch_in       = ch_ff;
      per_in      = per_ff;
      chan_in     = chan_ff;
      rsp_data_in = rsp_data_ff;
      unique case (ctl.action)
         A_WAIT: begin
            if (accepted) begin
               ch_in  = req_tdata[2:0];
               per_in = req_tdata[10:3];
            end
         end
         A_TICK: begin
            tick_in = tick_ff + TICK_W'(1);
            step_in = ALL_INACTIVE;
            chan_in = '0;
         end
         A_SCAN: begin
            if (period_ff[chan_ff] != '0 && due_ff[chan_ff] == tick_ff) begin
               due_in[chan_ff] = due_ff[chan_ff] + period_ff[chan_ff];
               step_in = step_ff & ~chan_mask;
               // reversal once the count passes the limit
               if (count_next > limit_ff) begin
                  dir_in            = dir_ff ^ chan_mask;
                  count_in[chan_ff] = '0;
               end else begin
                  count_in[chan_ff] = count_next;
               end
            end
            chan_in = last_chan ? '0 : chan_ff + IDX_W'(1);
         end
         A_SET: begin
            if ({1'b0, ch_ff} < CH_LIMIT) begin
               period_in[ch_ff[IDX_W-1:0]] = per_ff;
               due_in[ch_ff[IDX_W-1:0]]    = per_ff + tick_ff;
            end
         end
         A_EMIT: begin
            if (out_free) begin
               rsp_data_in = {dir_ff, step_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.action == A_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= REVERSE_RESET;
         tick_ff      <= '0;
         step_ff      <= ALL_INACTIVE;
         dir_ff       <= '0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            period_ff[i] <= '0;
            due_ff[i]    <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         tick_ff      <= tick_in;
         step_ff      <= step_in;
         dir_ff       <= dir_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         due_ff       <= due_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      per_ff      <= per_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // one item at a time: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("back-to-back acceptance");

   // unused channels keep their step bit released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_tdata[7:0] | (ALL_INACTIVE >> (PIN_W - CHANNELS))) == ALL_INACTIVE))
      else $error("step pin of unused channel driven");

   // scan index stays on a real channel
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, chan_ff} <= (IDX_W+1)'(CHANNELS - 1)))
      else $error("scan index out of range");
`endif

endmodule
`default_nettype wire

@@ test/tb_multi_channel_step_pulse_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_step_pulse_scheduler_core
// Drives tick and period-set transactions into the scheduler and keeps its own
// copy of the counter, due ticks, step counts and pin levels. Every returned
// transaction is compared against the oldest predicted pin pair. Random
// bursts and gaps on the request side and stalls on the response side are
// switched on per phase, and the reverse limit is changed between phases.
// ----------------------------------------------------------------------------
module tb_multi_channel_step_pulse_scheduler_core;
   import mcsps_pkg::*;

   localparam int CHANNELS   = 8;
   localparam int LONG_HOLD  = 150;
   localparam int DRAIN_MAX  = 20000;
   localparam int SETTLE     = CHANNELS + 4;

   typedef struct packed {
      logic [PIN_W-1:0] direction;
      logic [PIN_W-1:0] step;
   } pin_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [2:0] channel, [10:3] period, rest zero
   logic        req_tuser = 1'b0; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] step_pins, [15:8] direction_pins
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   // scheduler state as predicted
   logic [TICK_W-1:0] tick_now;
   logic [TICK_W-1:0] due_at [CHANNELS];
   logic [TICK_W-1:0] period_of [CHANNELS];
   logic [TICK_W-1:0] steps_taken [CHANNELS];
   logic [PIN_W-1:0]  step_level;
   logic [PIN_W-1:0]  dir_level;
   logic [TICK_W-1:0] reverse_limit_now;

   pin_pair_type pins_expected[$];
   int           mismatches = 0;

   // sender pacing
   int burst_left = 0;
   bit gaps_on = 1'b0;

   // receiver pacing
   logic        stalls_on = 1'b0;
   logic        hold_req = 1'b0;
   int          hold_left = 0;
   logic [15:0] stall_pattern = 16'hffff;
   int          pattern_age = 0;

   multi_channel_step_pulse_scheduler_core #(
      .CHANNELS(CHANNELS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one accepted transaction to the predicted scheduler state
   task automatic advance_scheduler(input logic op, input logic [CHAN_W-1:0] chan,
                                    input logic [TICK_W-1:0] per);
      pin_pair_type pins;
      int i;
      if (op == OP_SET) begin
         if (chan < CHANNELS) begin
            period_of[chan] = per;
            due_at[chan]    = per + tick_now;
         end
      end else begin
         tick_now   = tick_now + 8'd1;
         step_level = ALL_INACTIVE;
         for (i = 0; i < CHANNELS; i++) begin
            if (period_of[i] != 0 && due_at[i] == tick_now) begin
               due_at[i]      = due_at[i] + period_of[i];
               step_level[i]  = 1'b0;
               steps_taken[i] = steps_taken[i] + 8'd1;
               if (steps_taken[i] > reverse_limit_now) begin
                  dir_level[i]   = ~dir_level[i];
                  steps_taken[i] = '0;
               end
            end
         end
      end
      pins.step      = step_level;
      pins.direction = dir_level;
      pins_expected.push_back(pins);
   endtask

   task automatic send_item(input logic op, input logic [CHAN_W-1:0] chan,
                            input logic [TICK_W-1:0] per);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            gap = $urandom_range(1, 10);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, per, chan};
      do @(posedge clock); while (!req_tready);
      advance_scheduler(op, chan, per);
      burst_left = burst_left - 1;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 3'($urandom), 8'($urandom));
   endtask

   task automatic send_set(input logic [CHAN_W-1:0] chan, input logic [TICK_W-1:0] per);
      send_item(OP_SET, chan, per);
   endtask

   // mostly short periods so channels step often
   function automatic logic [TICK_W-1:0] pick_period();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 8'($urandom_range(1, 6));
      if (roll < 62) return 8'd0;
      return 8'($urandom);
   endfunction

   task automatic send_random_item();
      if ($urandom_range(0, 99) < 65) send_tick();
      else send_set(3'($urandom), pick_period());
   endtask

   // stop sending and wait until every predicted transaction has come back
   task automatic wait_for_pins(input int extra);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pins_expected.size() != 0 && waited < DRAIN_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reverse_limit(input logic [7:0] limit);
      wait_for_pins(SETTLE);
      csr_we    <= 1'b1;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      reverse_limit_now = limit;
   endtask

   task automatic test_directed_edges();
      gaps_on = 1'b0;
      stalls_on <= 1'b0;
      send_tick();                 // nothing enabled yet
      send_set(3'd0, 8'd1);
      send_tick();
      send_tick();
      send_set(3'd7, 8'd255);
      send_set(3'd5, 8'd0);        // disabled channel, due tick still written
      send_set(3'd2, 8'd128);
      send_set(3'd1, 8'haa);
      send_set(3'd6, 8'h55);
      send_set(3'd3, 8'd2);
      send_set(3'd4, 8'd3);
      repeat (4) send_tick();
      send_set(3'd0, 8'd0);        // levels of the last tick must stay put
      send_tick();
   endtask

   task automatic test_reverse_on_every_step();
      write_reverse_limit(8'd0);
      stalls_on <= 1'b1;
      send_set(3'd0, 8'd1);
      repeat (5) send_tick();
   endtask

   task automatic test_random_traffic(input int count, input logic [7:0] limit,
                                      input bit gaps, input bit stalls);
      write_reverse_limit(limit);
      gaps_on = gaps;
      stalls_on <= stalls;
      repeat (count) send_random_item();
   endtask

   task automatic test_backpressure();
      wait_for_pins(SETTLE);
      gaps_on = 1'b0;
      stalls_on <= 1'b0;
      hold_req <= 1'b1;
      repeat (14) send_random_item();
      // sender waits for every outstanding transaction before resuming
      wait_for_pins(0);
      repeat (4) send_random_item();
   endtask

   // limit 255 cannot be exceeded, so the step count of a busy channel wraps
   task automatic test_count_wrap();
      int n;
      write_reverse_limit(8'd255);
      gaps_on = 1'b1;
      stalls_on <= 1'b1;
      send_set(3'd0, 8'd1);
      for (n = 0; n < 270; n++) begin
         send_tick();
         if ($urandom_range(0, 9) == 0) send_set(3'($urandom_range(1, 7)), pick_period());
      end
   endtask

   // response side: long hold on request, else always ready or a rotating stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req   <= 1'b0;
         hold_left  = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!stalls_on) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= stall_pattern[0];
         pattern_age = pattern_age + 1;
         if (pattern_age >= 48) begin
            pattern_age = 0;
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff
                                                          : 16'($urandom_range(1, 16'hffff));
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
         end
      end
   end

   always @(posedge clock) begin
      pin_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pins_expected.size() == 0) begin
            $error("unexpected transaction: step_pins %h direction_pins %h",
                   rsp_tdata[7:0], rsp_tdata[15:8]);
            mismatches++;
         end else begin
            want = pins_expected.pop_front();
            if (rsp_tdata[7:0] !== want.step) begin
               $error("step_pins: expected %h, actual %h", want.step, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[15:8] !== want.direction) begin
               $error("direction_pins: expected %h, actual %h",
                      want.direction, rsp_tdata[15:8]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      tick_now          = '0;
      step_level        = ALL_INACTIVE;
      dir_level         = '0;
      reverse_limit_now = REVERSE_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
         due_at[i]      = '0;
         period_of[i]   = '0;
         steps_taken[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_reverse_on_every_step();
      test_random_traffic(60, 8'd1, 1'b1, 1'b1);
      test_random_traffic(60, 8'($urandom_range(2, 254)), 1'b0, 1'b0);
      test_backpressure();
      test_count_wrap();
      test_random_traffic(50, 8'd255, 1'b1, 1'b0);
      test_random_traffic(50, 8'd3, 1'b0, 1'b1);

      wait_for_pins(2 * SETTLE);
      if (mismatches == 0 && pins_expected.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (pins_expected.size() != 0)
            $error("%0d predicted transactions never returned", pins_expected.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mcsps_pkg.sv
rtl/core/mcsps_seq.sv
rtl/core/multi_channel_step_pulse_scheduler_core.sv
test/tb_multi_channel_step_pulse_scheduler_core.sv
